// ===== rtl/core/mlt_pkg.sv =====
// Shared types and constants for the MAC learning table.
`default_nettype none
package mlt_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    REQ_CONNECT = 2'd0,
    REQ_PKT_IN  = 2'd1,
    REQ_FLOW_RM = 2'd2,
    REQ_RSVD    = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    STS_OK          = 3'd0,
    STS_NOT_HANDLED = 3'd1,
    STS_UNKNOWN_SW  = 3'd2,
    STS_TABLE_FULL  = 3'd3,
    STS_PORT_CONFL  = 3'd4,
    STS_BCAST_SRC   = 3'd5,
    STS_CONNECTED   = 3'd6,
    STS_REG_FULL    = 3'd7
  } status_e;

  localparam logic [47:0] MAC_BCAST      = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] BASE_PRIO_RST  = 16'd100;
  localparam logic [31:0] FLOOD_PORT_RST = 32'hFFFF_FFFB;
  localparam logic [15:0] PRIO_MAX       = 16'hFFFF;
  localparam logic        REG_BASE_PRIO  = 1'b0;
  localparam logic        REG_FLOOD_PORT = 1'b1;

endpackage
`default_nettype wire

// ===== rtl/core/mac_learning_table.sv =====
// Top level: layer-2 MAC learning table with switch registry and APB config.
//
//  channel   | direction | handshake                     | beat
//  request   | in        | start_i && !busy_o            | req_type_i .. transaction_id_i
//  result    | out       | done_o (one cycle, no stall)  | status_o .. flow_priority_o
//  config    | in/out    | psel & penable & pwrite       | paddr / pwdata / prdata
//
// Connect, non-miss, unknown-switch and reserved requests raise done_o from ST_LOOK, through the done_o register.
// Packet-in and flow-removed for a known switch raise it after ST_SCAN and ST_FIN:
// one linear pass over the entry memory, one read port, one entry per cycle.
// Reset clears the switch registry and entry valid bits at once; no clearing pass.
// busy_o stays high from accept to the cycle before done_o; results are never held.
`default_nettype none
module mac_learning_table #(
  parameter int TABLE_ENTRIES = 256,
  parameter int NUM_SWITCHES  = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [63:0] datapath_id_i,
  input  wire logic        no_match_i,
  input  wire logic [31:0] in_port_i,
  input  wire logic [47:0] src_mac_i,
  input  wire logic [47:0] dst_mac_i,
  input  wire logic [31:0] buf_handle_i,
  input  wire logic [31:0] transaction_id_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic             send_packet_out_o,
  output logic [31:0]      out_port_o,
  output logic [31:0]      reply_in_port_o,
  output logic [31:0]      reply_buf_handle_o,
  output logic [31:0]      reply_transaction_id_o,
  output logic             install_flow_o,
  output logic [15:0]      flow_priority_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import mlt_pkg::*;

  localparam int AW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SW_W = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;
  localparam int MW   = SW_W + 48 + 32;
  localparam logic [AW:0] N_ENT = (AW+1)'(TABLE_ENTRIES);

  state_e state_q, state_d;

  // config
  logic [15:0] base_prio_q, prio_cnt_q;
  logic [31:0] flood_q;
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_FLOOD_PORT) ? flood_q : {16'd0, base_prio_q};

  // captured request
  logic [1:0]  req_q;
  logic [63:0] dpid_q;
  logic        miss_q;
  logic [31:0] inport_q, buf_q, xid_q;
  logic [47:0] src_q, dst_q;

  // registry
  logic [NUM_SWITCHES-1:0] sw_valid_q;
  logic [63:0]             sw_ids_q [NUM_SWITCHES];
  logic [SW_W-1:0]         sw_idx_q;

  // entry table
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [MW-1:0]            mem [TABLE_ENTRIES];
  logic [MW-1:0]            rd_q;
  logic [AW:0]              cnt_q;
  logic                     pend_q;
  logic [AW-1:0]            pidx_q;
  logic                     dhit_q, shit_q, free_q;
  logic [AW-1:0]            didx_q, fidx_q;
  logic [31:0]              dport_q, sport_q;

  // switch lookup over the registry
  logic            sw_hit, sw_free;
  logic [SW_W-1:0] sw_sel, sw_fsel;
  always_comb begin
    sw_hit  = 1'b0;
    sw_free = 1'b0;
    sw_sel  = '0;
    sw_fsel = '0;
    for (int s = NUM_SWITCHES - 1; s >= 0; s--) begin
      if (sw_valid_q[SW_W'(s)] && sw_ids_q[SW_W'(s)] == dpid_q) begin
        sw_hit = 1'b1;
        sw_sel = SW_W'(s);
      end
      if (!sw_valid_q[SW_W'(s)]) begin
        sw_free = 1'b1;
        sw_fsel = SW_W'(s);
      end
    end
  end

  // scan side
  logic            issue;
  logic [AW-1:0]   iaddr;
  logic [SW_W-1:0] e_sw;
  logic [47:0]     e_mac;
  logic [31:0]     e_port;
  logic            e_ok;
  assign issue  = (state_q == ST_SCAN) && (cnt_q < N_ENT);
  assign iaddr  = cnt_q[AW-1:0];
  assign e_sw   = rd_q[MW-1 -: SW_W];
  assign e_mac  = rd_q[79:32];
  assign e_port = rd_q[31:0];
  assign e_ok   = pend_q && valid_q[pidx_q] && (e_sw == sw_idx_q);

  // next state and result
  logic        res_fire, reg_add, learn, forget;
  logic [2:0]  res_sts;
  logic        res_send, res_inst;
  logic [31:0] res_oport;
  logic [15:0] prio_next;
  assign prio_next = (prio_cnt_q != PRIO_MAX) ? prio_cnt_q + 16'd1 : prio_cnt_q;

  always_comb begin
    state_d   = state_q;
    res_fire  = 1'b0;
    reg_add   = 1'b0;
    learn     = 1'b0;
    forget    = 1'b0;
    res_sts   = STS_OK;
    res_send  = 1'b0;
    res_inst  = 1'b0;
    res_oport = flood_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        state_d  = ST_IDLE;
        res_fire = 1'b1;
        case (req_q)
          REQ_CONNECT: begin
            if (sw_hit) res_sts = STS_CONNECTED;
            else if (sw_free) reg_add = 1'b1;
            else res_sts = STS_REG_FULL;
          end
          REQ_PKT_IN: begin
            if (!miss_q) begin
              res_sts = STS_NOT_HANDLED;
            end else if (!sw_hit) begin
              res_sts  = STS_UNKNOWN_SW;
              res_send = 1'b1;
            end else begin
              state_d  = ST_SCAN;
              res_fire = 1'b0;
            end
          end
          REQ_FLOW_RM: begin
            if (!sw_hit) begin
              res_sts = STS_UNKNOWN_SW;
            end else begin
              state_d  = ST_SCAN;
              res_fire = 1'b0;
            end
          end
          default: res_sts = STS_NOT_HANDLED;
        endcase
      end
      ST_SCAN: begin
        if (!issue && !pend_q) state_d = ST_FIN;
      end
      ST_FIN: begin
        state_d  = ST_IDLE;
        res_fire = 1'b1;
        if (req_q == REQ_PKT_IN) begin
          res_send = 1'b1;
          if (dst_q != MAC_BCAST && dhit_q) res_oport = dport_q;
          if (src_q == MAC_BCAST) res_sts = STS_BCAST_SRC;
          else if (shit_q) res_sts = (sport_q == inport_q) ? STS_OK : STS_PORT_CONFL;
          else if (free_q) begin
            learn    = 1'b1;
            res_inst = 1'b1;
          end else res_sts = STS_TABLE_FULL;
        end else begin
          forget = dhit_q;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  assign busy_o = (state_q != ST_IDLE);

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (learn) mem[fidx_q] <= {sw_idx_q, src_q, inport_q};
    if (issue) rd_q <= mem[iaddr];
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_q    <= req_type_i;
      dpid_q   <= datapath_id_i;
      miss_q   <= no_match_i;
      inport_q <= in_port_i;
      src_q    <= src_mac_i;
      dst_q    <= dst_mac_i;
      buf_q    <= buf_handle_i;
      xid_q    <= transaction_id_i;
    end
    if (state_q == ST_LOOK) sw_idx_q <= sw_sel;
    if (reg_add) sw_ids_q[sw_fsel] <= dpid_q;
    if (state_q == ST_LOOK) begin
      dhit_q <= 1'b0;
      shit_q <= 1'b0;
      free_q <= 1'b0;
    end else begin
      if (issue && !free_q && !valid_q[iaddr]) begin
        free_q <= 1'b1;
        fidx_q <= iaddr;
      end
      if (e_ok && e_mac == dst_q && !dhit_q) begin
        dhit_q  <= 1'b1;
        didx_q  <= pidx_q;
        dport_q <= e_port;
      end
      if (e_ok && e_mac == src_q && !shit_q) begin
        shit_q  <= 1'b1;
        sport_q <= e_port;
      end
    end
    if (issue) pidx_q <= iaddr;
    if (res_fire) begin
      status_o               <= res_sts;
      send_packet_out_o      <= res_send;
      out_port_o             <= res_send ? res_oport : '0;
      reply_in_port_o        <= res_send ? inport_q : '0;
      reply_buf_handle_o     <= res_send ? buf_q : '0;
      reply_transaction_id_o <= res_send ? xid_q : '0;
      install_flow_o         <= res_inst;
      flow_priority_o        <= res_inst ? prio_next : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_prio_q <= BASE_PRIO_RST;
      prio_cnt_q  <= BASE_PRIO_RST;
      flood_q     <= FLOOD_PORT_RST;
      sw_valid_q  <= '0;
      valid_q     <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      done_o      <= 1'b0;
    end else begin
      done_o <= res_fire;
      if (cfg_wr) begin
        if (paddr[2] == REG_FLOOD_PORT) begin
          flood_q <= pwdata;
        end else begin
          base_prio_q <= pwdata[15:0];
          prio_cnt_q  <= pwdata[15:0];
        end
      end
      if (reg_add) sw_valid_q[sw_fsel] <= 1'b1;
      if (learn) begin
        valid_q[fidx_q] <= 1'b1;
        prio_cnt_q      <= prio_next;
      end
      if (forget) valid_q[didx_q] <= 1'b0;
      if (state_q == ST_LOOK) cnt_q <= '0;
      else if (issue) cnt_q <= cnt_q + (AW+1)'(1);
      pend_q <= issue;
    end
  end

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result while busy");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accept did not raise busy");
  a_install_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && install_flow_o) |-> (send_packet_out_o && status_o == STS_OK))
    else $error("flow install without packet-out");
  a_scan_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (learn || forget) |-> (state_q == ST_FIN && !issue)) else $error("update during scan");

endmodule
`default_nettype wire

// ===== test/mac_learning_table_test.sv =====
// Self-checking testbench for the MAC learning table: scoreboard class plus task-driven stimulus.
`timescale 1ns / 100ps
module mac_learning_table_test;
  import mlt_pkg::*;

  localparam int NSW = 4;
  localparam int NENT = 256;
  localparam int LIMIT = 3_000_000;
  localparam int PHASE_ITEMS = 321;
  localparam logic [63:0] ID_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    req_e        req_type;
    logic [63:0] datapath_id;
    logic        no_match;
    logic [31:0] in_port;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [31:0] buf_handle;
    logic [31:0] transaction_id;
  } request_t;

  typedef struct {
    status_e     status;
    logic        send_packet_out;
    logic [31:0] out_port;
    logic [31:0] reply_in_port;
    logic [31:0] reply_buf_handle;
    logic [31:0] reply_transaction_id;
    logic        install_flow;
    logic [15:0] flow_priority;
  } result_t;

  class mac_table_scoreboard;
    logic [63:0] sw_id[NSW];
    bit          sw_ok[NSW];
    bit          ent_ok[NENT];
    int          ent_sw[NENT];
    logic [47:0] ent_mac[NENT];
    logic [31:0] ent_port[NENT];
    logic [15:0] prio_cnt;
    logic [31:0] flood;
    result_t     pending[$];
    int          errors;
    int          checked;
    int          status_seen[8];

    function new();
      foreach (sw_ok[i]) sw_ok[i] = 0;
      foreach (ent_ok[i]) ent_ok[i] = 0;
      prio_cnt = BASE_PRIO_RST;
      flood = FLOOD_PORT_RST;
    endfunction

    function void write_reg(logic idx, logic [31:0] v);
      if (idx == REG_BASE_PRIO) prio_cnt = v[15:0];
      else flood = v;
    endfunction

    function int find_sw(logic [63:0] id);
      for (int s = 0; s < NSW; s++)
        if (sw_ok[s] && sw_id[s] == id) return s;
      return -1;
    endfunction

    function int find_ent(int sw, logic [47:0] mac);
      for (int e = 0; e < NENT; e++)
        if (ent_ok[e] && ent_sw[e] == sw && ent_mac[e] == mac) return e;
      return -1;
    endfunction

    function void note_request(request_t r);
      result_t x;
      int sw;
      int e;
      x = '{STS_OK, 0, 0, 0, 0, 0, 0, 0};
      case (r.req_type)
        REQ_CONNECT: begin
          if (find_sw(r.datapath_id) >= 0) begin
            x.status = STS_CONNECTED;
          end else begin
            x.status = STS_REG_FULL;
            for (int s = 0; s < NSW; s++)
              if (!sw_ok[s]) begin
                sw_ok[s] = 1;
                sw_id[s] = r.datapath_id;
                x.status = STS_OK;
                break;
              end
          end
        end
        REQ_PKT_IN: begin
          if (!r.no_match) begin
            x.status = STS_NOT_HANDLED;
          end else begin
            x.send_packet_out = 1;
            x.out_port = flood;
            x.reply_in_port = r.in_port;
            x.reply_buf_handle = r.buf_handle;
            x.reply_transaction_id = r.transaction_id;
            sw = find_sw(r.datapath_id);
            if (sw < 0) begin
              x.status = STS_UNKNOWN_SW;
            end else begin
              if (r.dst_mac != MAC_BCAST) begin
                e = find_ent(sw, r.dst_mac);
                if (e >= 0) x.out_port = ent_port[e];
              end
              if (r.src_mac == MAC_BCAST) begin
                x.status = STS_BCAST_SRC;
              end else begin
                e = find_ent(sw, r.src_mac);
                if (e >= 0) begin
                  x.status = (ent_port[e] == r.in_port) ? STS_OK : STS_PORT_CONFL;
                end else begin
                  x.status = STS_TABLE_FULL;
                  for (int i = 0; i < NENT; i++)
                    if (!ent_ok[i]) begin
                      ent_ok[i] = 1;
                      ent_sw[i] = sw;
                      ent_mac[i] = r.src_mac;
                      ent_port[i] = r.in_port;
                      if (prio_cnt != PRIO_MAX) prio_cnt++;
                      x.install_flow = 1;
                      x.flow_priority = prio_cnt;
                      x.status = STS_OK;
                      break;
                    end
                end
              end
            end
          end
        end
        REQ_FLOW_RM: begin
          sw = find_sw(r.datapath_id);
          if (sw < 0) begin
            x.status = STS_UNKNOWN_SW;
          end else begin
            e = find_ent(sw, r.dst_mac);
            if (e >= 0) ent_ok[e] = 0;
          end
        end
        default: x.status = STS_NOT_HANDLED;
      endcase
      pending.push_back(x);
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t x;
      if (pending.size() == 0) begin
        $error("result beat with no request outstanding");
        errors++;
        return;
      end
      x = pending.pop_front();
      checked++;
      status_seen[x.status]++;
      check_field("status", x.status, got.status);
      check_field("send_packet_out", x.send_packet_out, got.send_packet_out);
      check_field("out_port", x.out_port, got.out_port);
      check_field("reply_in_port", x.reply_in_port, got.reply_in_port);
      check_field("reply_buf_handle", x.reply_buf_handle, got.reply_buf_handle);
      check_field("reply_transaction_id", x.reply_transaction_id, got.reply_transaction_id);
      check_field("install_flow", x.install_flow, got.install_flow);
      check_field("flow_priority", x.flow_priority, got.flow_priority);
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start_i = 0;
  logic        busy_o;
  logic [1:0]  req_type_i = '0;
  logic [63:0] datapath_id_i = '0;
  logic        no_match_i = 0;
  logic [31:0] in_port_i = '0;
  logic [47:0] src_mac_i = '0;
  logic [47:0] dst_mac_i = '0;
  logic [31:0] buf_handle_i = '0;
  logic [31:0] transaction_id_i = '0;
  logic        done_o;
  logic [2:0]  status_o;
  logic        send_packet_out_o;
  logic [31:0] out_port_o;
  logic [31:0] reply_in_port_o;
  logic [31:0] reply_buf_handle_o;
  logic [31:0] reply_transaction_id_o;
  logic        install_flow_o;
  logic [15:0] flow_priority_o;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  mac_learning_table u_top (.*);

  mac_table_scoreboard sb = new();
  int          cycles = 0;
  int          n_sent = 0;
  logic [63:0] sw_pool[NSW];
  logic [47:0] mac_pool[40];
  logic [47:0] fresh_mac[$];
  logic [63:0] fresh_dpid[$];

  initial forever #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && done_o)
      sb.check_result('{status_e'(status_o), send_packet_out_o, out_port_o, reply_in_port_o,
                        reply_buf_handle_o, reply_transaction_id_o, install_flow_o,
                        flow_priority_o});

  task automatic send_request(request_t r);
    start_i <= 1;
    req_type_i <= r.req_type;
    datapath_id_i <= r.datapath_id;
    no_match_i <= r.no_match;
    in_port_i <= r.in_port;
    src_mac_i <= r.src_mac;
    dst_mac_i <= r.dst_mac;
    buf_handle_i <= r.buf_handle;
    transaction_id_i <= r.transaction_id;
    do @(posedge clk_i); while (busy_o);
    sb.note_request(r);
    n_sent++;
  endtask

  task automatic idle(int n);
    start_i <= 0;
    repeat (n) @(posedge clk_i);
  endtask

  // hold requests until every outstanding result has come back
  task automatic drain();
    start_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(logic idx, logic [31:0] v);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.write_reg(idx, v);
  endtask

  function automatic logic [47:0] rand_mac();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic request_t mk(req_e t, logic [63:0] id, logic miss, logic [31:0] port,
                                  logic [47:0] src, logic [47:0] dst);
    return '{t, id, miss, port, src, dst, $urandom, $urandom};
  endfunction

  function automatic request_t rand_request(bit fill);
    request_t r;
    int k;
    r = mk(REQ_PKT_IN, sw_pool[$urandom_range(0, NSW - 1)], 1, $urandom_range(1, 4),
           mac_pool[$urandom_range(0, 39)], mac_pool[$urandom_range(0, 39)]);
    if (fill) begin
      r.src_mac = rand_mac();
      return r;
    end
    k = $urandom_range(0, 99);
    if (k < 8) r.req_type = REQ_CONNECT;
    else if (k < 22) r.req_type = REQ_FLOW_RM;
    else if (k < 26) r.req_type = REQ_RSVD;
    if ($urandom_range(0, 99) < 12) r.datapath_id = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 8) r.no_match = 0;
    k = $urandom_range(0, 99);
    if (k < 5) r.in_port = 0;
    else if (k < 10) r.in_port = '1;
    else if (k < 25) r.in_port = $urandom;
    k = $urandom_range(0, 99);
    if (k < 5) r.src_mac = MAC_BCAST;
    else if (k < 15) r.src_mac = rand_mac();
    k = $urandom_range(0, 99);
    if (k < 10) r.dst_mac = MAC_BCAST;
    else if (k < 20) r.dst_mac = rand_mac();
    if (r.req_type == REQ_FLOW_RM && fresh_mac.size() != 0 && $urandom_range(0, 1)) begin
      k = $urandom_range(0, fresh_mac.size() - 1);
      r.dst_mac = fresh_mac[k];
      r.datapath_id = fresh_dpid[k];
    end
    return r;
  endfunction

  initial begin
    request_t r;
    int k;
    sw_pool[0] = '0;
    sw_pool[1] = ID_ONES;
    sw_pool[2] = {$urandom, $urandom};
    sw_pool[3] = {$urandom, $urandom};
    foreach (mac_pool[i]) mac_pool[i] = rand_mac();
    mac_pool[0] = '0;
    mac_pool[1] = 48'hFFFF_FFFF_FFFE;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: registry, learning and every status code except STS_TABLE_FULL
    send_request(mk(REQ_PKT_IN, sw_pool[0], 1, 7, mac_pool[2], mac_pool[3]));
    send_request(mk(REQ_FLOW_RM, sw_pool[0], 0, 0, 0, mac_pool[2]));
    foreach (sw_pool[i]) send_request(mk(REQ_CONNECT, sw_pool[i], 0, 0, 0, 0));
    send_request(mk(REQ_CONNECT, sw_pool[0], 0, 0, 0, 0));
    send_request(mk(REQ_CONNECT, 64'h1234_5678_9ABC_DEF0, 0, 0, 0, 0));
    send_request(mk(REQ_PKT_IN, sw_pool[0], 0, 3, mac_pool[2], mac_pool[3]));
    send_request(mk(REQ_PKT_IN, sw_pool[0], 1, 3, mac_pool[2], MAC_BCAST));
    send_request(mk(REQ_PKT_IN, sw_pool[0], 1, 3, mac_pool[2], mac_pool[3]));
    send_request(mk(REQ_PKT_IN, sw_pool[0], 1, 9, mac_pool[2], mac_pool[3]));
    send_request(mk(REQ_PKT_IN, sw_pool[0], 1, 4, MAC_BCAST, mac_pool[2]));
    send_request(mk(REQ_PKT_IN, sw_pool[0], 1, 4, mac_pool[3], mac_pool[2]));
    send_request(mk(REQ_PKT_IN, sw_pool[1], 1, 0, mac_pool[0], mac_pool[2]));
    send_request(mk(REQ_PKT_IN, sw_pool[1], 1, '1, mac_pool[1], mac_pool[0]));
    send_request('{REQ_PKT_IN, sw_pool[2], 1, '1, ~48'h0 - 2, '0, '1, '1});
    send_request('{REQ_PKT_IN, sw_pool[2], 1, 0, 48'h0000_0000_0001, '1, 0, 0});
    send_request(mk(REQ_FLOW_RM, 64'h5555_AAAA_5555_AAAA, 0, 0, 0, mac_pool[2]));
    send_request(mk(REQ_FLOW_RM, sw_pool[0], 0, 0, 0, mac_pool[2]));
    send_request(mk(REQ_FLOW_RM, sw_pool[0], 0, 0, 0, mac_pool[9]));
    send_request(mk(REQ_PKT_IN, sw_pool[0], 1, 5, mac_pool[4], mac_pool[2]));
    send_request(mk(REQ_RSVD, sw_pool[0], 1, 5, mac_pool[5], mac_pool[2]));

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        1: begin reg_write(REG_BASE_PRIO, 0); reg_write(REG_FLOOD_PORT, 0); end
        2: begin reg_write(REG_BASE_PRIO, 16'hFFFF); reg_write(REG_FLOOD_PORT, '1); end
        3: begin reg_write(REG_BASE_PRIO, 16'd65500); reg_write(REG_FLOOD_PORT, $urandom); end
        4: begin
          reg_write(REG_BASE_PRIO, $urandom_range(0, 65535));
          reg_write(REG_FLOOD_PORT, $urandom);
        end
        5: begin reg_write(REG_BASE_PRIO, BASE_PRIO_RST); reg_write(REG_FLOOD_PORT, FLOOD_PORT_RST); end
        default: ;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // phase 3 opens by flooding the shared pool past its capacity
        r = rand_request(ph == 3 && n < 280);
        if (r.req_type == REQ_PKT_IN && r.no_match && sb.find_sw(r.datapath_id) >= 0 &&
            r.src_mac != MAC_BCAST && sb.find_ent(sb.find_sw(r.datapath_id), r.src_mac) < 0) begin
          fresh_mac.push_back(r.src_mac);
          fresh_dpid.push_back(r.datapath_id);
        end
        send_request(r);
        if (!(ph == 5 && n > PHASE_ITEMS / 2)) begin
          k = $urandom_range(0, 99);
          if (k < 2) drain();
          else if (k < 30) idle($urandom_range(1, 6));
        end
      end
    end

    drain();
    repeat (NENT + 10) @(posedge clk_i);
    $display("%0d requests sent, %0d results checked over six register settings", n_sent,
             sb.checked);
    $display("status mix: ok %0d, not handled %0d, unknown sw %0d, full %0d, conflict %0d",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
             sb.status_seen[4]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
